/* rtl/cgsr_pkg.sv */
package cgsr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;
    localparam int MAX_SIZE_DEF      = 63;

    localparam int SZ_W   = 8;
    localparam int CNT_W  = 9;
    localparam int OFS_W  = 11;
    localparam int POS_W  = 12;
    localparam int IJ_W   = 10;
    localparam int SQ_W   = 18;
    localparam int FIFO_DEPTH = 2;

    localparam logic [7:0]  CLEAR_GLYPH = 8'h20;
    localparam logic [15:0] CLEAR_COLOR = 16'd7;

    localparam logic [2:0] ACT_SHAPE = 3'd0;
    localparam logic [2:0] ACT_LINE  = 3'd1;
    localparam logic [2:0] ACT_MOVE  = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;

    localparam logic [2:0] SHP_TRI  = 3'd0;
    localparam logic [2:0] SHP_SQR  = 3'd1;
    localparam logic [2:0] SHP_RECT = 3'd2;
    localparam logic [2:0] SHP_CIRC = 3'd3;
    localparam logic [2:0] SHP_RHOM = 3'd4;
    localparam logic [2:0] SHP_HEX  = 3'd5;

    localparam logic [3:0] ORI_UP    = 4'd1;
    localparam logic [3:0] ORI_DOWN  = 4'd2;
    localparam logic [3:0] ORI_LEFT  = 4'd3;
    localparam logic [3:0] ORI_RIGHT = 4'd4;
    localparam logic [3:0] ORI_UL    = 4'd5;
    localparam logic [3:0] ORI_UR    = 4'd6;
    localparam logic [3:0] ORI_DL    = 4'd7;
    localparam logic [3:0] ORI_DR    = 4'd8;

    localparam logic [2:0] HEX_LAST_SEG = 3'd5;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SCAN,
        OP_WALK,
        OP_MOVE,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_NORM,
        BK_SCAN,
        BK_WALK,
        BK_READ,
        BK_RESP
    } t_bk_state;

    typedef struct packed {
        t_op                     op;
        logic [2:0]              shp;
        logic                    hex;
        logic signed [1:0]       dir_x;
        logic signed [1:0]       dir_y;
        logic signed [OFS_W-1:0] off_x;
        logic signed [OFS_W-1:0] off_y;
        logic signed [IJ_W-1:0]  j0;
        logic signed [IJ_W-1:0]  i0;
        logic [CNT_W-1:0]        n_cols;
        logic [CNT_W-1:0]        n_rows;
        logic [SZ_W-1:0]         s;
        logic [SZ_W-1:0]         t;
        logic [15:0]             color;
        logic [7:0]              glyph;
        logic signed [1:0]       step_x;
        logic signed [1:0]       step_y;
        logic [6:0]              cell_x;
        logic [4:0]              cell_y;
    } t_cmd;

    function automatic logic signed [1:0] hex_dx(input logic [2:0] k);
        logic signed [1:0] v;
        unique case (k)
            3'd0, 3'd1: v = 2'sd1;
            3'd3, 3'd4: v = -2'sd1;
            default:    v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] hex_dy(input logic [2:0] k);
        logic signed [1:0] v;
        unique case (k)
            3'd1, 3'd2: v = 2'sd1;
            3'd4, 3'd5: v = -2'sd1;
            default:    v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/cgsr_ram.sv */
module cgsr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/cgsr_fifo.sv */
module cgsr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cgsr_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output cgsr_pkg::t_cmd  o_data,
    output logic            o_empty
);
    import cgsr_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_cmd            r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
endmodule

/* rtl/cgsr_front.sv */
module cgsr_front #(
    parameter int MAX_SIZE = cgsr_pkg::MAX_SIZE_DEF
) (
    input  logic        i_action_valid,
    input  logic [2:0]  i_action,
    input  logic [2:0]  i_shape,
    input  logic [3:0]  i_orientation,
    input  logic [5:0]  i_size_a,
    input  logic [5:0]  i_size_b,
    input  logic [15:0] i_color,
    input  logic [7:0]  i_glyph,
    input  logic signed [1:0] i_step_x,
    input  logic signed [1:0] i_step_y,
    input  logic [6:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    input  logic        i_hold,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output cgsr_pkg::t_cmd o_cmd
);
    import cgsr_pkg::*;

    logic [SZ_W-1:0]         sa, sb, hh, hs;
    logic signed [OFS_W-1:0] shx, shy;
    t_cmd                    c;

    always_comb begin
        sa = (SZ_W'(i_size_a) > SZ_W'(MAX_SIZE)) ? SZ_W'(MAX_SIZE) : SZ_W'(i_size_a);
        sb = (SZ_W'(i_size_b) > SZ_W'(MAX_SIZE)) ? SZ_W'(MAX_SIZE) : SZ_W'(i_size_b);
        hh = sa >> 1;
        if (i_shape == SHP_TRI || i_shape == SHP_CIRC) begin
            hs = '0;
        end else if (i_shape == SHP_RECT) begin
            hs = sb;
        end else begin
            hs = sa;
        end
        shx = '0;
        shy = '0;
        priority if (i_orientation == ORI_UP) begin
            shy = -OFS_W'(hs);
        end else if (i_orientation == ORI_LEFT) begin
            shx = -OFS_W'(sa);
        end else begin
            shy = '0;
        end

        c        = '0;
        c.op     = OP_NONE;
        c.s      = sa;
        c.t      = sb;
        c.shp    = i_shape;
        c.color  = i_color;
        c.glyph  = i_glyph;
        c.step_x = i_step_x;
        c.step_y = i_step_y;
        c.cell_x = i_cell_x;
        c.cell_y = i_cell_y;

        case (i_action)
            ACT_SHAPE: begin
                c.op = OP_SCAN;
                case (i_shape)
                    SHP_TRI: begin
                        c.j0     = -IJ_W'(hh);
                        c.n_cols = CNT_W'({hh, 1'b1});
                        c.n_rows = CNT_W'(hh) + 1'b1;
                    end
                    SHP_SQR: begin
                        c.n_cols = CNT_W'(sa);
                        c.n_rows = CNT_W'(sa);
                    end
                    SHP_RECT: begin
                        c.n_cols = CNT_W'(sa);
                        c.n_rows = CNT_W'(sb);
                    end
                    SHP_CIRC: begin
                        c.j0     = -IJ_W'(sa);
                        c.i0     = -IJ_W'(sa);
                        c.n_cols = (sa == '0) ? '0 : CNT_W'({sa, 1'b1});
                        c.n_rows = c.n_cols;
                    end
                    SHP_RHOM: begin
                        c.j0     = -IJ_W'(sa);
                        c.i0     = -IJ_W'(sa);
                        c.n_cols = CNT_W'({sa, 1'b1});
                        c.n_rows = CNT_W'({sa, 1'b1});
                    end
                    SHP_HEX: begin
                        c.op  = OP_WALK;
                        c.hex = 1'b1;
                    end
                    default: c.op = OP_NONE;
                endcase
                c.off_x = shx + OFS_W'(c.j0);
                c.off_y = shy + OFS_W'(c.i0);
            end
            ACT_LINE: begin
                c.op = OP_WALK;
                case (i_orientation)
                    ORI_UP:    begin c.dir_x = 2'sd0;  c.dir_y = -2'sd1; end
                    ORI_DOWN:  begin c.dir_x = 2'sd0;  c.dir_y = 2'sd1;  end
                    ORI_LEFT:  begin c.dir_x = -2'sd1; c.dir_y = 2'sd0;  end
                    ORI_RIGHT: begin c.dir_x = 2'sd1;  c.dir_y = 2'sd0;  end
                    ORI_UL:    begin c.dir_x = -2'sd1; c.dir_y = -2'sd1; end
                    ORI_UR:    begin c.dir_x = 2'sd1;  c.dir_y = -2'sd1; end
                    ORI_DL:    begin c.dir_x = -2'sd1; c.dir_y = 2'sd1;  end
                    ORI_DR:    begin c.dir_x = 2'sd1;  c.dir_y = 2'sd1;  end
                    default:   c.op = OP_NONE;
                endcase
            end
            ACT_MOVE:  c.op = OP_MOVE;
            ACT_CLEAR: c.op = OP_CLEAR;
            default:   c.op = OP_NONE;
        endcase
    end

    assign o_ready = !i_full && !i_hold;
    assign o_push  = i_action_valid && o_ready;
    assign o_cmd   = c;
endmodule

/* rtl/cgsr_back.sv */
module cgsr_back #(
    parameter int SCREEN_WIDTH  = cgsr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cgsr_pkg::SCREEN_HEIGHT_DEF,
    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT,
    localparam int AW    = $clog2(CELLS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cgsr_pkg::t_cmd  i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_init,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output logic [23:0]     o_wdata,
    output logic            o_re,
    output logic [AW-1:0]   o_raddr,
    input  logic [23:0]     i_rdata,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_cell_glyph,
    output logic [15:0]     o_cell_color,
    output logic [6:0]      o_cursor_col,
    output logic [4:0]      o_cursor_row
);
    import cgsr_pkg::*;

    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam logic signed [POS_W-1:0] W_S = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] H_S = POS_W'(SCREEN_HEIGHT);

    t_bk_state r_state, n_state;
    t_cmd      r_cmd, n_cmd;
    logic [XW-1:0] r_cur_x, n_cur_x;
    logic [YW-1:0] r_cur_y, n_cur_y;
    logic signed [POS_W-1:0] r_px, n_px, r_py, n_py, r_rx, n_rx, r_ry, n_ry;
    logic signed [POS_W-1:0] r_px0, n_px0, r_rx0, n_rx0;
    logic signed [IJ_W-1:0]  r_j, n_j, r_i, n_i;
    logic [SQ_W-1:0]  r_jsq, n_jsq, r_isq, n_isq, r_ssq, n_ssq;
    logic [CNT_W-1:0] r_ccnt, n_ccnt, r_rcnt, n_rcnt;
    logic [2:0]       r_seg, n_seg;
    logic [AW-1:0]    r_caddr, n_caddr;
    logic             r_fill, n_fill, r_init, n_init, r_oob, n_oob;
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_oglyph, n_oglyph;
    logic [15:0]      r_ocolor, n_ocolor;
    logic [6:0]       r_ocol, n_ocol;
    logic [4:0]       r_orow, n_orow;

    logic signed [POS_W-1:0] sx, sy;
    logic signed [1:0]       dx, dy;
    logic signed [SQ_W:0]    diff;
    logic [CNT_W-1:0]        aj, ai, hh, hb;
    logic x_ok, y_ok, pv, pred, row_end, last_row, step_end, last_seg;
    logic in_scr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_CLEAR;
            r_cur_x  <= XW'(SCREEN_WIDTH / 2);
            r_cur_y  <= YW'(SCREEN_HEIGHT / 2);
            r_caddr  <= '0;
            r_fill   <= 1'b0;
            r_init   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_caddr  <= n_caddr;
            r_fill   <= n_fill;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_px     <= n_px;
        r_py     <= n_py;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_px0    <= n_px0;
        r_rx0    <= n_rx0;
        r_j      <= n_j;
        r_i      <= n_i;
        r_jsq    <= n_jsq;
        r_isq    <= n_isq;
        r_ssq    <= n_ssq;
        r_ccnt   <= n_ccnt;
        r_rcnt   <= n_rcnt;
        r_seg    <= n_seg;
        r_oob    <= n_oob;
        r_oglyph <= n_oglyph;
        r_ocolor <= n_ocolor;
        r_ocol   <= n_ocol;
        r_orow   <= n_orow;
    end

    always_comb begin
        x_ok     = (r_rx >= 0) && (r_rx < W_S);
        y_ok     = (r_ry >= 0) && (r_ry < H_S);
        pv       = ((r_px >= -W_S) || (r_rx == '0)) && ((r_py >= -H_S) || (r_ry == '0));
        row_end  = (r_ccnt == r_cmd.n_cols - 1'b1);
        last_row = (r_rcnt == r_cmd.n_rows - 1'b1);
        step_end = (r_ccnt == CNT_W'(r_cmd.s) - 1'b1);
        last_seg = r_cmd.hex ? (r_seg == HEX_LAST_SEG) : 1'b1;
        aj       = CNT_W'((r_j < 0) ? -r_j : r_j);
        ai       = CNT_W'((r_i < 0) ? -r_i : r_i);
        hh       = CNT_W'(r_cmd.s >> 1);
        hb       = (r_cmd.shp == SHP_SQR) ? CNT_W'(r_cmd.s) : CNT_W'(r_cmd.t);
        diff     = $signed({1'b0, r_jsq}) + $signed({1'b0, r_isq}) - $signed({1'b0, r_ssq});
        case (r_cmd.shp)
            SHP_TRI:  pred = (aj <= r_rcnt) && ((r_rcnt == hh) || (aj == r_rcnt));
            SHP_SQR, SHP_RECT:
                pred = (r_rcnt == '0) || (r_rcnt == hb - 1'b1) || (r_ccnt == '0)
                    || (r_ccnt == CNT_W'(r_cmd.s) - 1'b1);
            SHP_CIRC: pred = (((diff < 0) ? -diff : diff) < (SQ_W+1)'(r_cmd.s));
            SHP_RHOM: pred = (aj + ai == CNT_W'(r_cmd.s));
            default:  pred = 1'b0;
        endcase
        dx = r_cmd.hex ? hex_dx(r_seg) : r_cmd.dir_x;
        dy = r_cmd.hex ? hex_dy(r_seg) : r_cmd.dir_y;
        in_scr = (int'(r_cmd.cell_x) < SCREEN_WIDTH) && (int'(r_cmd.cell_y) < SCREEN_HEIGHT);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: if (r_caddr == AW'(CELLS - 1)) n_state = r_init ? BK_IDLE : BK_READ;
            BK_IDLE: begin
                if (!i_empty) begin
                    unique case (i_cmd.op)
                        OP_CLEAR: n_state = BK_CLEAR;
                        OP_SCAN:  n_state = (i_cmd.n_cols == '0 || i_cmd.n_rows == '0)
                                            ? BK_READ : BK_NORM;
                        OP_WALK:  n_state = (i_cmd.s == '0) ? BK_READ : BK_NORM;
                        default:  n_state = BK_READ;
                    endcase
                end
            end
            BK_NORM: if (x_ok && y_ok) n_state = (r_cmd.op == OP_WALK) ? BK_WALK : BK_SCAN;
            BK_SCAN: if (row_end && last_row) n_state = BK_READ;
            BK_WALK: if (step_end && last_seg) n_state = BK_READ;
            BK_READ: n_state = BK_RESP;
            BK_RESP: if (!r_ovalid || i_ready) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = r_cmd;  n_cur_x = r_cur_x; n_cur_y = r_cur_y;
        n_px = r_px;  n_py = r_py;  n_rx = r_rx;  n_ry = r_ry;
        n_px0 = r_px0; n_rx0 = r_rx0; n_j = r_j; n_i = r_i;
        n_jsq = r_jsq; n_isq = r_isq; n_ssq = r_ssq;
        n_ccnt = r_ccnt; n_rcnt = r_rcnt; n_seg = r_seg;
        n_caddr = r_caddr; n_fill = r_fill; n_init = r_init; n_oob = r_oob;
        n_ovalid = r_ovalid && !i_ready;
        n_oglyph = r_oglyph; n_ocolor = r_ocolor; n_ocol = r_ocol; n_orow = r_orow;
        o_pop = 1'b0; o_we = 1'b0; o_re = 1'b0;
        o_waddr = AW'(AW'(r_ry[YW-1:0]) * AW'(SCREEN_WIDTH) + AW'(r_rx[XW-1:0]));
        o_wdata = {r_cmd.glyph, r_cmd.color};
        o_raddr = AW'(AW'(r_cmd.cell_y) * AW'(SCREEN_WIDTH) + AW'(r_cmd.cell_x));
        sx = POS_W'(r_cur_x) + POS_W'(i_cmd.step_x);
        sy = POS_W'(r_cur_y) + POS_W'(i_cmd.step_y);

        unique case (r_state)
            BK_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_caddr;
                o_wdata = r_fill ? {CLEAR_GLYPH, CLEAR_COLOR} : '0;
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == AW'(CELLS - 1)) begin
                    n_caddr = '0;
                    n_init  = 1'b0;
                end
            end
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_cmd;
                    n_fill = 1'b1;
                    n_px   = POS_W'(r_cur_x) + POS_W'(i_cmd.off_x);
                    n_py   = POS_W'(r_cur_y) + POS_W'(i_cmd.off_y);
                    n_rx   = n_px;
                    n_ry   = n_py;
                    n_j    = i_cmd.j0;
                    n_i    = i_cmd.i0;
                    n_ccnt = '0;
                    n_rcnt = '0;
                    n_seg  = '0;
                    n_ssq  = SQ_W'(i_cmd.s) * SQ_W'(i_cmd.s);
                    if (i_cmd.op == OP_MOVE) begin
                        n_cur_x = XW'((sx < 0) ? sx + W_S : ((sx >= W_S) ? sx - W_S : sx));
                        n_cur_y = YW'((sy < 0) ? sy + H_S : ((sy >= H_S) ? sy - H_S : sy));
                    end
                end
            end
            BK_NORM: begin
                n_rx  = (r_rx < 0) ? r_rx + W_S : ((r_rx >= W_S) ? r_rx - W_S : r_rx);
                n_ry  = (r_ry < 0) ? r_ry + H_S : ((r_ry >= H_S) ? r_ry - H_S : r_ry);
                n_px0 = r_px;
                n_rx0 = r_rx;
                n_jsq = r_ssq;
                n_isq = r_ssq;
            end
            BK_SCAN: begin
                o_we = pv && pred;
                if (row_end) begin
                    n_ccnt = '0;
                    n_j    = r_cmd.j0;
                    n_px   = r_px0;
                    n_rx   = r_rx0;
                    n_jsq  = r_ssq;
                    n_rcnt = r_rcnt + 1'b1;
                    n_i    = r_i + 1'b1;
                    n_py   = r_py + 1'b1;
                    n_ry   = (r_ry == H_S - 1) ? '0 : r_ry + 1'b1;
                    n_isq  = SQ_W'($signed({1'b0, r_isq}) + ((SQ_W+1)'(r_i) <<< 1) + 1);
                end else begin
                    n_ccnt = r_ccnt + 1'b1;
                    n_j    = r_j + 1'b1;
                    n_px   = r_px + 1'b1;
                    n_rx   = (r_rx == W_S - 1) ? '0 : r_rx + 1'b1;
                    n_jsq  = SQ_W'($signed({1'b0, r_jsq}) + ((SQ_W+1)'(r_j) <<< 1) + 1);
                end
            end
            BK_WALK: begin
                o_we = pv;
                n_px = r_px + POS_W'(dx);
                n_py = r_py + POS_W'(dy);
                if (dx > 0) begin
                    n_rx = (r_rx == W_S - 1) ? '0 : r_rx + 1'b1;
                end else if (dx < 0) begin
                    n_rx = (r_rx == '0) ? POS_W'(W_S - 1) : r_rx - 1'b1;
                end
                if (dy > 0) begin
                    n_ry = (r_ry == H_S - 1) ? '0 : r_ry + 1'b1;
                end else if (dy < 0) begin
                    n_ry = (r_ry == '0) ? POS_W'(H_S - 1) : r_ry - 1'b1;
                end
                if (step_end) begin
                    n_ccnt = '0;
                    n_seg  = r_seg + 1'b1;
                end else begin
                    n_ccnt = r_ccnt + 1'b1;
                end
            end
            BK_READ: begin
                o_re  = in_scr;
                n_oob = !in_scr;
            end
            BK_RESP: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oglyph = r_oob ? '0 : i_rdata[23:16];
                    n_ocolor = r_oob ? '0 : i_rdata[15:0];
                    n_ocol   = 7'(r_cur_x);
                    n_orow   = 5'(r_cur_y);
                end
            end
            default: n_ovalid = r_ovalid && !i_ready;
        endcase
    end

    assign o_init       = r_init;
    assign o_valid      = r_ovalid;
    assign o_cell_glyph = r_oglyph;
    assign o_cell_color = r_ocolor;
    assign o_cursor_col = r_ocol;
    assign o_cursor_row = r_orow;
endmodule

/* rtl/char_grid_shape_rasterizer_unit.sv */
// Move, read and empty draws go from idle to read to response; a draw first wraps its
// origin, then visits each bounding-box cell (up to (2*MAX_SIZE+1)^2) or walk step.
// Throughput: one command at a time in the walker; a clear sweeps all cells, one a cycle.
// The command queue holds two beats, so input beats are taken while the walker is busy.
// Reset: synchronous, active low; a sweep of all SCREEN_WIDTH*SCREEN_HEIGHT cells zeroes
// the screen, during which no input beat is taken. Cursor resets to the screen centre.
module char_grid_shape_rasterizer_unit #(
    parameter int SCREEN_WIDTH  = cgsr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cgsr_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_SIZE      = cgsr_pkg::MAX_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [2:0]  i_shape,
    input  logic [3:0]  i_orientation,
    input  logic [5:0]  i_size_a,
    input  logic [5:0]  i_size_b,
    input  logic [15:0] i_color,
    input  logic [7:0]  i_glyph,
    input  logic signed [1:0] i_step_x,
    input  logic signed [1:0] i_step_y,
    input  logic [6:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_cell_glyph,
    output logic [15:0] o_cell_color,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row
);
    import cgsr_pkg::*;

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);

    t_cmd          w_cmd_in, w_cmd_out;
    logic          w_push, w_pop, w_full, w_empty, w_init;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [23:0]   w_wdata, w_rdata;

    cgsr_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .i_action_valid(i_valid),
        .i_action(i_action), .i_shape(i_shape), .i_orientation(i_orientation),
        .i_size_a(i_size_a), .i_size_b(i_size_b), .i_color(i_color), .i_glyph(i_glyph),
        .i_step_x(i_step_x), .i_step_y(i_step_y), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_hold(w_init), .i_full(w_full), .o_ready(o_ready), .o_push(w_push),
        .o_cmd(w_cmd_in)
    );

    cgsr_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_cmd_in), .o_full(w_full),
        .i_pop(w_pop), .o_data(w_cmd_out), .o_empty(w_empty)
    );

    cgsr_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd_out), .i_empty(w_empty), .o_pop(w_pop), .o_init(w_init),
        .o_we(w_we), .o_waddr(w_waddr), .o_wdata(w_wdata),
        .o_re(w_re), .o_raddr(w_raddr), .i_rdata(w_rdata),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_cell_glyph(o_cell_glyph), .o_cell_color(o_cell_color),
        .o_cursor_col(o_cursor_col), .o_cursor_row(o_cursor_row)
    );

    cgsr_ram #(.WIDTH(24), .DEPTH(CELLS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_re(w_re), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

`ifndef SYNTH
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !o_ready)
        else $error("input beat taken during reset sweep");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue overrun");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty && !w_init)
        else $error("command queue underrun");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_cursor_row) < SCREEN_HEIGHT || SCREEN_HEIGHT > 32))
        else $error("cursor row off screen");
`endif
endmodule
